// ----- hdl/io_ports_interval_timer_top_macros.svh -----
// ----------------------------------------------------------------------------
// I/O ports and interval timer: assertion macros
// Shared wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef IO_PORTS_INTERVAL_TIMER_TOP_MACROS_SVH
`define IO_PORTS_INTERVAL_TIMER_TOP_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define IOPIT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("iopit check failed");

// The condition must never be seen outside reset.
`define IOPIT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `IOPIT_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ----- hdl/iopit_pkg.sv -----
// ----------------------------------------------------------------------------
// I/O ports and interval timer: package
// Item types, codes and constants shared by the block's modules.
// ----------------------------------------------------------------------------
package iopit_pkg;

  localparam int unsigned TICKS_W = 19;

  localparam logic [7:0]         FLAG_BIT     = 8'h80;
  localparam logic [TICKS_W-1:0] FINISH_TICKS = TICKS_W'(256);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PHASE_IDLE      = 3'b001,
    PHASE_COUNTING  = 3'b010,
    PHASE_FINISHING = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] address;
    logic [7:0] write_data;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       irq_pending;
  } out_item_t;

  // Timer request for one accepted item.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       tick;
    logic [3:0] address;
    logic [7:0] data;
  } tmr_cmd_t;

  // Timer status: current view and the values after the present item.
  typedef struct packed {
    logic [7:0] value;
    logic       flag_q;
    logic       en_q;
    logic       flag_d;
    logic       en_d;
  } tmr_stat_t;

  // Prescaler: 1, 8, 64 or 1024 ticks.
  function automatic logic [3:0] shift_for(input logic [1:0] sel);
    logic [3:0] s;
    unique case (sel)
      2'd0:    s = 4'd0;
      2'd1:    s = 4'd3;
      2'd2:    s = 4'd6;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

  // Port B as driven: bit 7 shows the inverted flag when the interrupt is enabled.
  function automatic logic [7:0] port_b_view(input logic [7:0] latch, input logic en,
                                             input logic flag);
    return en ? {~flag, latch[6:0]} : latch;
  endfunction

endpackage

// ----- hdl/io_ports_interval_timer_top.sv -----
// ----------------------------------------------------------------------------
// I/O ports and interval timer: top level
// Two 8-bit ports with latch and direction registers, and an interval timer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       to block   in_valid_i/in_stall_o   in_item_i   (in_item_t)
//  out      from block out_valid_o/out_stall_i out_item_o  (out_item_t)
//
// Each item's result is captured in the output register at the accepting edge
// and can be taken at the next one, and a new item may be accepted every cycle
// unless a waiting result is stalled by the output side.
// Reset clears ports and timer, and sets the interrupt flag.
// Input is stalled only while a result waits and the output side stalls.
// ----------------------------------------------------------------------------
`include "io_ports_interval_timer_top_macros.svh"

module io_ports_interval_timer_top import iopit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic       in_acc;
  logic [7:0] latch_a_q, latch_a_d;
  logic [7:0] dir_a_q, dir_a_d;
  logic [7:0] latch_b_q, latch_b_d;
  logic [7:0] dir_b_q, dir_b_d;
  logic       out_valid_q;
  out_item_t  out_q;
  logic [7:0] rd_data;
  logic       is_wr;
  logic       is_rd;
  tmr_cmd_t   tmr_cmd;
  tmr_stat_t  tmr_stat;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_wr      = in_acc && (in_item_i.kind == KIND_WRITE);
  assign is_rd      = in_acc && (in_item_i.kind == KIND_READ);

  assign tmr_cmd = '{
    wr:      is_wr && in_item_i.address[2],
    rd:      is_rd && in_item_i.address[2] && !in_item_i.address[0],
    tick:    in_acc && (in_item_i.kind == KIND_TICK),
    address: in_item_i.address,
    data:    in_item_i.write_data
  };

  iopit_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tmr_cmd),
    .stat_o (tmr_stat)
  );

  always_comb begin
    latch_a_d = latch_a_q;
    dir_a_d   = dir_a_q;
    latch_b_d = latch_b_q;
    dir_b_d   = dir_b_q;
    if (is_wr && !in_item_i.address[2]) begin
      unique case (in_item_i.address[1:0])
        2'd0:    latch_a_d = in_item_i.write_data;
        2'd1:    dir_a_d   = in_item_i.write_data;
        2'd2:    latch_b_d = in_item_i.write_data;
        default: dir_b_d   = in_item_i.write_data;
      endcase
    end
  end

  // Reads see the state as it stood before the item.
  always_comb begin
    rd_data = 8'h00;
    if (in_item_i.kind == KIND_READ) begin
      priority if (in_item_i.address[2] && in_item_i.address[0]) begin
        rd_data = tmr_stat.flag_q ? FLAG_BIT : 8'h00;
      end else if (in_item_i.address[2]) begin
        rd_data = tmr_stat.value;
      end else if (in_item_i.address[1]) begin
        rd_data = in_item_i.address[0] ? dir_b_q :
                  ((port_b_view(latch_b_q, tmr_stat.en_q, tmr_stat.flag_q) & dir_b_q) |
                   (in_item_i.pins_b & ~dir_b_q));
      end else begin
        rd_data = in_item_i.address[0] ? dir_a_q :
                  ((latch_a_q & dir_a_q) | (in_item_i.pins_a & ~dir_a_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_a_q   <= '0;
      dir_a_q     <= '0;
      latch_b_q   <= '0;
      dir_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      latch_a_q <= latch_a_d;
      dir_a_q   <= dir_a_d;
      latch_b_q <= latch_b_d;
      dir_b_q   <= dir_b_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.read_data    <= rd_data;
      out_q.port_a_drive <= latch_a_d;
      out_q.port_b_drive <= port_b_view(latch_b_d, tmr_stat.en_d, tmr_stat.flag_d);
      out_q.irq_pending  <= tmr_stat.flag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `IOPIT_ASSERT(a_accept_shows, clk_i, rst_ni, in_acc |=> out_valid_q)
  `IOPIT_ASSERT_NEVER(a_idle_stall, clk_i, rst_ni, !out_valid_q && in_stall_o)
  `IOPIT_ASSERT(a_port_a_match, clk_i, rst_ni,
                out_valid_q |-> (out_q.port_a_drive == latch_a_q))
  `IOPIT_ASSERT(a_flag_match, clk_i, rst_ni,
                out_valid_q |-> (out_q.irq_pending == tmr_stat.flag_q))

endmodule

// ----- hdl/iopit_timer.sv -----
// ----------------------------------------------------------------------------
// I/O ports and interval timer: interval timer
// Prescaled down-counter with its interrupt flag and enable.
// ----------------------------------------------------------------------------
`include "io_ports_interval_timer_top_macros.svh"

module iopit_timer import iopit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tmr_cmd_t  cmd_i,
  output tmr_stat_t stat_o
);

  phase_e             phase_q, phase_d;
  logic [TICKS_W-1:0] ticks_q, ticks_d;
  logic [3:0]         shift_q, shift_d;
  logic               flag_q, flag_d;
  logic               en_q, en_d;
  logic [7:0]         value;
  logic [TICKS_W-1:0] scaled;
  logic [TICKS_W-1:0] dec;
  logic               hold_flag;

  assign scaled = ticks_q >> shift_q;
  assign dec    = (ticks_q == '0) ? '0 : ticks_q - TICKS_W'(1);

  always_comb begin
    unique case (phase_q)
      PHASE_COUNTING:  value = scaled[7:0];
      PHASE_FINISHING: value = ticks_q[7:0];
      default:         value = 8'h00;
    endcase
  end

  // An access that sees the count at 0xFF during the final run leaves the flag set.
  assign hold_flag = (phase_q == PHASE_FINISHING) && (value == 8'hFF);

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    shift_d = shift_q;
    flag_d  = flag_q;
    en_d    = en_q;
    if (cmd_i.wr) begin
      shift_d = shift_for(cmd_i.address[1:0]);
      en_d    = cmd_i.address[3];
      if (!hold_flag) begin
        flag_d = 1'b0;
      end
      phase_d = PHASE_COUNTING;
      ticks_d = TICKS_W'(1) + (TICKS_W'(cmd_i.data) << shift_d);
    end else if (cmd_i.rd) begin
      en_d = cmd_i.address[3];
      if (!hold_flag) begin
        flag_d = 1'b0;
      end
    end else if (cmd_i.tick && phase_q != PHASE_IDLE) begin
      ticks_d = dec;
      if (dec == '0) begin
        if (phase_q == PHASE_COUNTING) begin
          phase_d = PHASE_FINISHING;
          ticks_d = FINISH_TICKS;
          flag_d  = 1'b1;
        end else begin
          phase_d = PHASE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_IDLE;
      ticks_q <= '0;
      shift_q <= '0;
      flag_q  <= 1'b1;
      en_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      shift_q <= shift_d;
      flag_q  <= flag_d;
      en_q    <= en_d;
    end
  end

  assign stat_o = '{value: value, flag_q: flag_q, en_q: en_q, flag_d: flag_d, en_d: en_d};

  `IOPIT_ASSERT(a_idle_empty, clk_i, rst_ni, (phase_q == PHASE_IDLE) |-> (ticks_q == '0))
  `IOPIT_ASSERT_NEVER(a_counting_zero, clk_i, rst_ni,
                      (phase_q == PHASE_COUNTING) && (ticks_q == '0))
  `IOPIT_ASSERT(a_finish_bound, clk_i, rst_ni,
                (phase_q == PHASE_FINISHING) |-> (ticks_q <= FINISH_TICKS))
  `IOPIT_ASSERT(a_expiry_flags, clk_i, rst_ni,
                ((phase_q == PHASE_FINISHING) && ($past(phase_q) == PHASE_COUNTING))
                |-> flag_q)

endmodule

// ----- test/iopit_checker.sv -----
// ----------------------------------------------------------------------------
// I/O ports and interval timer: result checker
// Watches both channels, predicts each result from the accepted items and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module iopit_checker import iopit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_o,
  output int        expiries_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted state of the ports and the timer.
  logic [7:0]         latch_a_m, dir_a_m, latch_b_m, dir_b_m;
  logic               flag_m, irq_en_m;
  logic [3:0]         shift_m;
  phase_e             phase_m;
  logic [TICKS_W-1:0] ticks_m;

  out_item_t awaited_q[$];

  function automatic logic [7:0] timer_reading();
    logic [7:0] v;
    v = 8'h00;
    if (phase_m == PHASE_COUNTING) v = 8'(ticks_m >> shift_m);
    else if (phase_m == PHASE_FINISHING) v = ticks_m[7:0];
    return v;
  endfunction

  function automatic logic [7:0] port_b_driven();
    logic [7:0] v;
    v = latch_b_m;
    if (irq_en_m) v[7] = ~flag_m;
    return v;
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  task automatic predict_port_timer(input in_item_t it, output out_item_t res);
    logic [7:0] rd, tv;
    rd = 8'h00;
    tv = timer_reading();
    case (it.kind)
      KIND_WRITE: begin
        if (it.address[2]) begin
          case (it.address[1:0])
            2'd0:    shift_m = 4'd0;
            2'd1:    shift_m = 4'd3;
            2'd2:    shift_m = 4'd6;
            default: shift_m = 4'd10;
          endcase
          irq_en_m = it.address[3];
          if (!(phase_m == PHASE_FINISHING && tv == 8'hFF)) flag_m = 1'b0;
          phase_m = PHASE_COUNTING;
          ticks_m = TICKS_W'(1) + (TICKS_W'(it.write_data) << shift_m);
        end else if (it.address[1]) begin
          if (it.address[0]) dir_b_m = it.write_data;
          else latch_b_m = it.write_data;
        end else begin
          if (it.address[0]) dir_a_m = it.write_data;
          else latch_a_m = it.write_data;
        end
      end
      KIND_READ: begin
        if (it.address[2] && it.address[0]) begin
          rd = flag_m ? FLAG_BIT : 8'h00;
        end else if (it.address[2]) begin
          // A timer read that lands on 0xFF while finishing leaves the flag set.
          rd = tv;
          irq_en_m = it.address[3];
          if (!(phase_m == PHASE_FINISHING && tv == 8'hFF)) flag_m = 1'b0;
        end else if (it.address[1]) begin
          if (it.address[0]) rd = dir_b_m;
          else rd = (port_b_driven() & dir_b_m) | (it.pins_b & ~dir_b_m);
        end else begin
          if (it.address[0]) rd = dir_a_m;
          else rd = (latch_a_m & dir_a_m) | (it.pins_a & ~dir_a_m);
        end
      end
      KIND_TICK: begin
        if (phase_m != PHASE_IDLE) begin
          if (ticks_m != '0) ticks_m = ticks_m - 1'b1;
          if (ticks_m == '0) begin
            if (phase_m == PHASE_COUNTING) begin
              phase_m = PHASE_FINISHING;
              ticks_m = FINISH_TICKS;
              flag_m = 1'b1;
              expiries_o++;
            end else begin
              phase_m = PHASE_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
    res.read_data    = rd;
    res.port_a_drive = latch_a_m;
    res.port_b_drive = port_b_driven();
    res.irq_pending  = flag_m;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t res, want;
    if (!rst_ni) begin
      latch_a_m  = 8'h00;
      dir_a_m    = 8'h00;
      latch_b_m  = 8'h00;
      dir_b_m    = 8'h00;
      flag_m     = 1'b1;
      irq_en_m   = 1'b0;
      shift_m    = 4'd0;
      phase_m    = PHASE_IDLE;
      ticks_m    = '0;
      awaited_q.delete();
      pending_o  = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_port_timer(in_item_i, res);
        awaited_q.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result %h arrived with no item waiting", $time, out_item_i);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          check_field("read_data", want.read_data, out_item_i.read_data);
          check_field("port_a_drive", want.port_a_drive, out_item_i.port_a_drive);
          check_field("port_b_drive", want.port_b_drive, out_item_i.port_b_drive);
          check_field("irq_pending", 8'(want.irq_pending), 8'(out_item_i.irq_pending));
          results_o++;
        end
      end
      pending_o = awaited_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    results_o    = 0;
    expiries_o   = 0;
    pending_o    = 0;
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// I/O ports and interval timer: testbench top
// Drives directed and random bus accesses and clock ticks through the block
// under four idling patterns and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top import iopit_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         QUIET_LIMIT = 5000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int fail_count, pending, results, expiries;
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;

  io_ports_interval_timer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  iopit_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .expiries_o   (expiries)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Acceptance is sampled at the edge so that the driver never races the block.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic put_item(input logic [1:0] k, input logic [3:0] a, input logic [7:0] d,
                          input logic [7:0] pa, input logic [7:0] pb);
    in_item_t it;
    it.kind       = k;
    it.address    = a;
    it.write_data = d;
    it.pins_a     = pa;
    it.pins_b     = pb;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(negedge clk_i); while (!in_taken);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic rand_item(input logic [1:0] k, input logic [3:0] a);
    put_item(k, a, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // A timer, flag or port B read; port B data can show the inverted flag on bit 7.
  task automatic look_at_timer();
    case ($urandom_range(0, 2))
      0:       rand_item(KIND_READ, {1'($urandom), 1'b1, 1'($urandom), 1'b0});
      1:       rand_item(KIND_READ, {1'($urandom), 1'b1, 1'($urandom), 1'b1});
      default: rand_item(KIND_READ, {1'($urandom), 2'b01, 1'($urandom)});
    endcase
  endtask

  task automatic timer_sequence(input logic [1:0] sel, input logic [7:0] load,
                                input int n_ticks);
    int i;
    rand_item(KIND_WRITE, {1'($urandom), 1'b1, sel});
    put_item(KIND_WRITE, {1'($urandom), 1'b1, sel}, load, 8'($urandom), 8'($urandom));
    for (i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 99) < 25) look_at_timer();
      rand_item(KIND_TICK, 4'($urandom));
    end
  endtask

  task automatic short_timer_sequence();
    logic [1:0] sel;
    logic [7:0] load;
    int span;
    sel = 2'($urandom_range(0, 99) < 60 ? 0 : $urandom_range(1, 3));
    case (sel)
      2'd0: begin load = 8'($urandom_range(0, 40)); span = load;      end
      2'd1: begin load = 8'($urandom_range(0, 5));  span = load * 8;  end
      2'd2: begin load = 8'($urandom_range(0, 1));  span = load * 64; end
      default: begin load = 8'h00; span = 0; end
    endcase
    timer_sequence(sel, load, $urandom_range(0, span + 10));
  endtask

  // Lets the timer expire and then run through its whole finishing count.
  task automatic run_out();
    timer_sequence(2'd0, 8'($urandom_range(0, 3)), 262 + $urandom_range(0, 6));
  endtask

  task automatic random_phase(input int target);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(2, 6))
          rand_item(2'($urandom_range(0, 1)), {1'($urandom), 1'b0, 2'($urandom)});
      end else if (pick < 80) begin
        short_timer_sequence();
      end else begin
        rand_item(2'($urandom), 4'($urandom));
      end
    end
  endtask

  task automatic directed_items();
    put_item(KIND_READ, 4'h5, 8'h00, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h4, 8'h00, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h5, 8'h00, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h0, 8'hFF, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h1, 8'hFF, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h0, 8'h00, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h1, 8'h00, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h8, 8'h00, 8'hFF, 8'h00);
    put_item(KIND_WRITE, 4'h2, 8'hFF, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h3, 8'hF0, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h2, 8'h00, 8'h00, 8'h0F);
    // Slowest prescaler with a load of zero expires on the first tick.
    put_item(KIND_WRITE, 4'hF, 8'h00, 8'h00, 8'h00);
    put_item(KIND_READ, 4'hA, 8'h00, 8'h00, 8'h55);
    put_item(KIND_TICK, 4'h0, 8'h00, 8'h00, 8'h00);
    put_item(KIND_READ, 4'hD, 8'h00, 8'h00, 8'h00);
    put_item(KIND_TICK, 4'h0, 8'h00, 8'h00, 8'h00);
    // Reading 0xFF while finishing keeps the flag, and so does a write then.
    put_item(KIND_READ, 4'hC, 8'h00, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'hC, 8'hFF, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h4, 8'h00, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h6, 8'h80, 8'h00, 8'h00);
    put_item(KIND_UNUSED, 4'hF, 8'hFF, 8'hFF, 8'hFF);
    put_item(KIND_WRITE, 4'h7, 8'hFF, 8'h00, 8'h00);
    put_item(KIND_READ, 4'h4, 8'h00, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h3, 8'h00, 8'h00, 8'h00);
    put_item(KIND_WRITE, 4'h0, 8'h00, 8'h00, 8'h00);
  endtask

  initial begin
    int ph;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_items();
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 45; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if (ph == 0) run_out();
      random_phase(15);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Sent %0d items over four idling patterns and checked %0d results.",
             items_sent, results);
    $display("The timer expired %0d times; %0d field mismatches were seen.",
             expiries, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/iopit_pkg.sv
hdl/iopit_timer.sv
hdl/io_ports_interval_timer_top.sv
test/iopit_checker.sv
test/tb_top.sv
